// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bmw_pkg.sv =====
package bmw_pkg;

	localparam int ADDR_W = 12;
	localparam int ADDR_SPAN = 'h1000;
	localparam int CMD_W = 3;

	// bus command codes
	localparam logic [CMD_W-1:0] CMD_SET_CTRL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET_COLOR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MAGIC_WR = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PLAIN_WR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PLAIN_RD = 3'd4;
	localparam logic [CMD_W-1:0] CMD_COLL_RD = 3'd5;

	// control register bit positions
	localparam int CTL_ROTATE = 2;
	localparam int CTL_EXPAND = 3;
	localparam int CTL_OR = 4;
	localparam int CTL_XOR = 5;
	localparam int CTL_FLOP = 6;

	// collision flag masks per pixel field (bits 1:0 up to bits 7:6)
	localparam logic [7:0] COLL_P3 = 8'h88;
	localparam logic [7:0] COLL_P2 = 8'h44;
	localparam logic [7:0] COLL_P1 = 8'h22;
	localparam logic [7:0] COLL_P0 = 8'h11;
	localparam logic [7:0] COLL_KEEP = 8'h0f;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load;   // latch a word and read the old RAM byte
		logic exec;   // compute, write back, present result
		logic clear;  // clearing pass after reset
	} dp_ctrl_t;

	typedef struct packed {
		logic clear_last;
	} dp_stat_t;

endpackage

// ===== src/bmw_ctrl.sv =====
module bmw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bmw_pkg::dp_stat_t  stat,
	output logic               busy,
	output bmw_pkg::dp_ctrl_t  ctrl
);

	bmw_pkg::state_t state_q;
	bmw_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		busy       = 1'b1;
		ctrl.load  = 1'b0;
		ctrl.exec  = 1'b0;
		ctrl.clear = 1'b0;
		unique case (state_q)
			bmw_pkg::ST_CLEAR: begin
				ctrl.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = bmw_pkg::ST_IDLE;
				end
			end
			bmw_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = bmw_pkg::ST_EXEC;
				end
			end
			bmw_pkg::ST_EXEC: begin
				ctrl.exec = 1'b1;
				state_d   = bmw_pkg::ST_IDLE;
			end
			default: begin
				state_d = bmw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/bmw_datapath.sv =====
module bmw_datapath #(
	parameter int RAM_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bmw_pkg::dp_ctrl_t               ctrl,
	input  logic [bmw_pkg::CMD_W-1:0]       cmd,
	input  logic [bmw_pkg::ADDR_W-1:0]      address,
	input  logic [7:0]                      wdata,
	output bmw_pkg::dp_stat_t               stat,
	output logic                            done,
	output logic [7:0]                      rdata
);

	localparam int DEPTH = (RAM_BYTES < bmw_pkg::ADDR_SPAN) ? RAM_BYTES : bmw_pkg::ADDR_SPAN;
	localparam int IDX_W = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];

	// latched word
	logic [bmw_pkg::CMD_W-1:0] cmd_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      in_range_q;
	logic [7:0]                wdata_q;
	logic [7:0]                old_q;

	// blitter state
	logic [6:0] ctl_q;
	logic [3:0] color_q;
	logic       nib_q;
	logic [7:0] carry_q;
	logic [7:0] coll_q;
	logic       done_q;
	logic [7:0] rdata_q;
	logic [IDX_W-1:0] clr_q;

	logic        in_range;
	logic [3:0]  nib;
	logic [7:0]  px;
	logic [7:0]  d_exp;
	logic [1:0]  shamt;
	logic        shift_on;
	logic [15:0] sh;
	logic [7:0]  d_sh;
	logic [7:0]  d_mir;
	logic [7:0]  old;
	logic [7:0]  coll_d;
	logic [7:0]  d_out;
	logic        magic;
	logic        we;
	logic [IDX_W-1:0] waddr;
	logic [7:0]  wval;

	assign in_range = 32'(address) < 32'(RAM_BYTES);
	assign stat.clear_last = (clr_q == IDX_W'(DEPTH - 1));

	// expand: selected nibble, MSB first, into four pixels
	assign nib = nib_q ? wdata_q[3:0] : wdata_q[7:4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			px[7-2*k -: 2] = nib[3-k] ? color_q[3:2] : color_q[1:0];
		end
	end
	assign d_exp = ctl_q[bmw_pkg::CTL_EXPAND] ? px : wdata_q;

	// shift right by 2n; low byte of sh is what falls out
	assign shamt    = ctl_q[1:0];
	assign shift_on = !ctl_q[bmw_pkg::CTL_ROTATE] && (shamt != 2'd0);
	assign sh       = {d_exp, 8'h00} >> {shamt, 1'b0};
	assign d_sh     = shift_on ? (sh[15:8] | carry_q) : d_exp;

	assign d_mir = ctl_q[bmw_pkg::CTL_FLOP] ? {d_sh[1:0], d_sh[3:2], d_sh[5:4], d_sh[7:6]}
	                                        : d_sh;

	assign old = in_range_q ? old_q : 8'h00;

	always_comb begin
		coll_d = coll_q & bmw_pkg::COLL_KEEP;
		if ((d_mir[1:0] != 2'b00) && (old[1:0] != 2'b00)) coll_d = coll_d | bmw_pkg::COLL_P3;
		if ((d_mir[3:2] != 2'b00) && (old[3:2] != 2'b00)) coll_d = coll_d | bmw_pkg::COLL_P2;
		if ((d_mir[5:4] != 2'b00) && (old[5:4] != 2'b00)) coll_d = coll_d | bmw_pkg::COLL_P1;
		if ((d_mir[7:6] != 2'b00) && (old[7:6] != 2'b00)) coll_d = coll_d | bmw_pkg::COLL_P0;
	end

	always_comb begin
		if (ctl_q[bmw_pkg::CTL_XOR]) begin
			d_out = d_mir ^ old;
		end else if (ctl_q[bmw_pkg::CTL_OR]) begin
			d_out = d_mir | old;
		end else begin
			d_out = d_mir;
		end
	end

	assign magic = ctrl.exec && (cmd_q == bmw_pkg::CMD_MAGIC_WR);

	// single write port: clearing pass or write-back
	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wval  = 8'h00;
		if (ctrl.clear) begin
			we = 1'b1;
		end else if (ctrl.exec && in_range_q) begin
			waddr = idx_q;
			if (cmd_q == bmw_pkg::CMD_MAGIC_WR) begin
				we   = 1'b1;
				wval = d_out;
			end else if (cmd_q == bmw_pkg::CMD_PLAIN_WR) begin
				we   = 1'b1;
				wval = wdata_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wval;
		end
		if (ctrl.load) begin
			old_q <= mem[address[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q      <= cmd;
			idx_q      <= address[IDX_W-1:0];
			in_range_q <= in_range;
			wdata_q    <= wdata;
		end
		if (ctrl.exec) begin
			if (cmd_q == bmw_pkg::CMD_PLAIN_RD) begin
				rdata_q <= old;
			end else if (cmd_q == bmw_pkg::CMD_COLL_RD) begin
				rdata_q <= coll_q;
			end else begin
				rdata_q <= 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= '0;
			color_q <= '0;
			nib_q   <= 1'b0;
			carry_q <= '0;
			coll_q  <= '0;
			done_q  <= 1'b0;
			clr_q   <= '0;
		end else begin
			done_q <= ctrl.exec;
			if (ctrl.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctrl.exec) begin
				case (cmd_q)
					bmw_pkg::CMD_SET_CTRL: begin
						ctl_q   <= wdata_q[6:0];
						nib_q   <= 1'b0;
						carry_q <= '0;
					end
					bmw_pkg::CMD_SET_COLOR: begin
						color_q <= wdata_q[3:0];
					end
					bmw_pkg::CMD_COLL_RD: begin
						coll_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (magic) begin
				nib_q <= ~nib_q;
				if (shift_on) begin
					carry_q <= sh[7:0];
				end
				if (ctl_q[bmw_pkg::CTL_OR] || ctl_q[bmw_pkg::CTL_XOR]) begin
					coll_q <= coll_d;
				end
			end
		end
	end

	assign done  = done_q;
	assign rdata = rdata_q;

endmodule

// ===== src/blitter_magic_write.sv =====
// Video RAM write path with a 2-bit-per-pixel blitter.
// Command channel: present cmd/address/wdata with start; the word is taken
// at a rising edge where start is high and busy is low.
// Result channel: rdata is valid for exactly one cycle while done is high.
// It holds the RAM byte for a plain read, the collision byte for a
// collision read-clear, and zero for every other command. The receiver
// cannot stall the block; it must take the result in that cycle.
// The accepting edge latches the word and reads the old byte into a register;
// the EXEC state then computes and writes back, and done and rdata are
// registered at its end.
// A new word waits while the read-modify-write on the single-port RAM keeps
// busy high; busy drops in the cycle that done is shown, so the next
// word overlaps the result.
// Reset: control, colors, nibble select, carry and collision bytes clear
// at once. The RAM is then swept to zero, one byte per cycle, over
// min(RAM_BYTES, 4096) bytes; busy stays high for the whole sweep.
// Addresses at or above RAM_BYTES drop writes and read as zero.
`include "assert_macros.svh"

module blitter_magic_write #(
	parameter int RAM_BYTES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [bmw_pkg::CMD_W-1:0]   cmd,
	input  logic [bmw_pkg::ADDR_W-1:0]  address,
	input  logic [7:0]                  wdata,
	output logic                        done,
	output logic [7:0]                  rdata
);

	bmw_pkg::dp_ctrl_t ctrl;
	bmw_pkg::dp_stat_t stat;
	logic              accept;

	assign accept = start && !busy;

	bmw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	bmw_datapath #(
		.RAM_BYTES (RAM_BYTES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.cmd     (cmd),
		.address (address),
		.wdata   (wdata),
		.stat    (stat),
		.done    (done),
		.rdata   (rdata)
	);

	// every accepted word is answered by a done strobe after its write-back
	`ASSERT_NEXT(a_done_after_accept, clk, arst_n, accept, ##1 done, "missing result strobe")
	// the result cycle is always open for a new word
	`ASSERT_IMPLIES(a_done_not_busy, clk, arst_n, done, !busy, "result shown while busy")
	// the cycle after an accept is the write-back, never open
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy && ctrl.exec, "no write-back cycle")

endmodule

// ===== dv/blitter_magic_write_tb.sv =====
module blitter_magic_write_tb;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 6;
	// margin after the last expected result has been checked
	localparam int SETTLE_CYCLES = 6;
	// slowest clean run is the RAM clear sweep plus about 960 words, each
	// with its sender gap and accept wait; allow over 10x that
	localparam int RUN_LIMIT = 1_200_000;
	localparam int RANDOM_WORDS = 900;
	localparam int MAX_PRINTED = 40;

	// command codes the block does not decode; they must answer zero
	localparam logic [bmw_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [bmw_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

	// one expected result: command and address kept only for messages
	typedef struct {
		logic [bmw_pkg::CMD_W-1:0]  cmd;
		logic [bmw_pkg::ADDR_W-1:0] addr;
		logic [7:0]                 rdata;
	} bus_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [bmw_pkg::CMD_W-1:0]  cmd = bmw_pkg::CMD_PLAIN_RD;
	logic [bmw_pkg::ADDR_W-1:0] address = '0;
	logic [7:0]                 wdata = 8'h00;
	logic                       done;
	logic [7:0]                 rdata;

	// predictor state: a shadow of everything the blitter remembers
	logic [7:0] vram_shadow [bmw_pkg::ADDR_SPAN];
	logic [6:0] ctl_shadow;
	logic [3:0] colors_shadow;
	logic       nib_sel_shadow;   // 0: upper nibble next, 1: lower
	logic [7:0] carry_shadow;     // pixels shifted out by the last shifting magic write
	logic [7:0] coll_shadow;

	bus_result_t expected_rdata_q[$];
	int          error_count = 0;
	// sender gap on/off; off gives back-to-back stretches
	bit          idle_enable = 1'b1;

	blitter_magic_write i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.address (address),
		.wdata   (wdata),
		.done    (done),
		.rdata   (rdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		if (error_count < MAX_PRINTED)
			$display("[%0t] mismatch: %s got %02h want %02h", $time, what, got, want);
		error_count++;
	endtask

	// Predict one accepted bus word: update the shadow state and queue the
	// rdata the block has to return for it.
	task automatic predict_bus_word(input logic [bmw_pkg::CMD_W-1:0] c,
		input logic [bmw_pkg::ADDR_W-1:0] a, input logic [7:0] d);
		bus_result_t r;
		logic [7:0]  pix;
		logic [7:0]  old;
		logic [7:0]  spill;
		logic [7:0]  coll;
		logic [3:0]  nib;
		int          n;
		r.cmd = c;
		r.addr = a;
		r.rdata = 8'h00;
		case (c)
			bmw_pkg::CMD_SET_CTRL: begin
				ctl_shadow = d[6:0];
				nib_sel_shadow = 1'b0;
				carry_shadow = 8'h00;
			end
			bmw_pkg::CMD_SET_COLOR: colors_shadow = d[3:0];
			bmw_pkg::CMD_MAGIC_WR: begin
				pix = d;
				// expand: each nibble bit picks one of two 2-bit colors,
				// MSB of the nibble lands in pixel 0 (bits 7:6)
				if (ctl_shadow[bmw_pkg::CTL_EXPAND]) begin
					nib = nib_sel_shadow ? d[3:0] : d[7:4];
					for (int k = 0; k < 4; k++)
						pix[7-2*k -: 2] = nib[3-k] ? colors_shadow[3:2] : colors_shadow[1:0];
				end
				// shift right by whole pixels; rotate mode means no shift and
				// leaves the carry alone
				n = int'(ctl_shadow[1:0]);
				if (!ctl_shadow[bmw_pkg::CTL_ROTATE] && n != 0) begin
					spill = pix << (8 - 2*n);
					pix = (pix >> (2*n)) | carry_shadow;
					carry_shadow = spill;
				end
				if (ctl_shadow[bmw_pkg::CTL_FLOP])
					pix = {pix[1:0], pix[3:2], pix[5:4], pix[7:6]};
				old = vram_shadow[a];
				// collision: high nibble rebuilt per word, low nibble sticky
				if (ctl_shadow[bmw_pkg::CTL_OR] || ctl_shadow[bmw_pkg::CTL_XOR]) begin
					coll = coll_shadow & bmw_pkg::COLL_KEEP;
					if (pix[1:0] != 2'b00 && old[1:0] != 2'b00) coll |= bmw_pkg::COLL_P3;
					if (pix[3:2] != 2'b00 && old[3:2] != 2'b00) coll |= bmw_pkg::COLL_P2;
					if (pix[5:4] != 2'b00 && old[5:4] != 2'b00) coll |= bmw_pkg::COLL_P1;
					if (pix[7:6] != 2'b00 && old[7:6] != 2'b00) coll |= bmw_pkg::COLL_P0;
					coll_shadow = coll;
				end
				// XOR wins over OR when both are set
				if (ctl_shadow[bmw_pkg::CTL_XOR])
					pix ^= old;
				else if (ctl_shadow[bmw_pkg::CTL_OR])
					pix |= old;
				vram_shadow[a] = pix;
				nib_sel_shadow = ~nib_sel_shadow;
			end
			bmw_pkg::CMD_PLAIN_WR: vram_shadow[a] = d;
			bmw_pkg::CMD_PLAIN_RD: r.rdata = vram_shadow[a];
			bmw_pkg::CMD_COLL_RD: begin
				r.rdata = coll_shadow;
				coll_shadow = 8'h00;
			end
			default: ;
		endcase
		expected_rdata_q.push_back(r);
	endtask

	// Send one word. Entered and left at a rising edge. start is only
	// lowered when a gap follows, so a back-to-back word never sees start
	// dropped and raised in the same step. busy is looked at on the falling
	// edge, clear of the rising edge that takes the word.
	task automatic send_word(input logic [bmw_pkg::CMD_W-1:0] c,
		input logic [bmw_pkg::ADDR_W-1:0] a, input logic [7:0] d);
		int gap;
		gap = idle_enable ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			// junk on the bus while idle; the block has to ignore it
			cmd <= bmw_pkg::CMD_W'($urandom);
			address <= bmw_pkg::ADDR_W'($urandom);
			wdata <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		address <= a;
		wdata <= d;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		predict_bus_word(c, a, d);
	endtask

	// Result side: done is a one-cycle strobe, so it is checked mid-cycle.
	always @(negedge clk) begin
		bus_result_t e;
		if (arst_n && done === 1'b1) begin
			if (expected_rdata_q.size() == 0) begin
				report_mismatch("done with no word pending, rdata", rdata, 8'h00);
			end else begin
				e = expected_rdata_q.pop_front();
				if (rdata !== e.rdata)
					report_mismatch($sformatf("cmd %0d addr %03h rdata", e.cmd, e.addr),
						rdata, e.rdata);
			end
		end
	end

	// Plain writes and reads at both ends of RAM, a byte never written (the
	// clear sweep must have zeroed it) and the two undecoded commands.
	task automatic test_plain_access();
		send_word(bmw_pkg::CMD_PLAIN_WR, 12'h000, 8'hff);
		send_word(bmw_pkg::CMD_PLAIN_WR, 12'hfff, 8'ha5);
		send_word(bmw_pkg::CMD_PLAIN_RD, 12'h000, 8'h00);
		send_word(bmw_pkg::CMD_PLAIN_RD, 12'hfff, 8'hff);
		send_word(bmw_pkg::CMD_PLAIN_RD, 12'h064, 8'h00);
		send_word(CMD_SPARE6, 12'h000, 8'hff);
		send_word(CMD_SPARE7, 12'hfff, 8'hff);
	endtask

	// Expand mode: upper nibble first, then lower. Color byte has junk in
	// its top bits that must be dropped.
	task automatic test_nibble_expand();
		send_word(bmw_pkg::CMD_SET_COLOR, 12'h000, 8'hfe);
		send_word(bmw_pkg::CMD_SET_CTRL, 12'h000, 8'(1 << bmw_pkg::CTL_EXPAND));
		send_word(bmw_pkg::CMD_MAGIC_WR, 12'h00a, 8'h5a);
		send_word(bmw_pkg::CMD_MAGIC_WR, 12'h00b, 8'h5a);
	endtask

	// Shift by 3 pixels: full byte, then the carry flushing into an empty
	// one. Rotate with a nonzero count must not shift.
	task automatic test_shift_and_rotate();
		send_word(bmw_pkg::CMD_SET_CTRL, 12'h000, 8'h03);
		send_word(bmw_pkg::CMD_MAGIC_WR, 12'h014, 8'hff);
		send_word(bmw_pkg::CMD_MAGIC_WR, 12'h015, 8'h00);
		send_word(bmw_pkg::CMD_SET_CTRL, 12'h000, 8'(1 << bmw_pkg::CTL_ROTATE) | 8'h03);
		send_word(bmw_pkg::CMD_MAGIC_WR, 12'h016, 8'he4);
	endtask

	// Mirror + XOR over a full byte (collides on three of four pixels), read-clear
	// twice, OR mode at the top address, and every control bit at once.
	task automatic test_combine_and_collision();
		send_word(bmw_pkg::CMD_SET_CTRL, 12'h000,
			8'((1 << bmw_pkg::CTL_FLOP) | (1 << bmw_pkg::CTL_XOR) | (1 << bmw_pkg::CTL_OR)));
		send_word(bmw_pkg::CMD_MAGIC_WR, 12'h000, 8'h1b);
		send_word(bmw_pkg::CMD_COLL_RD, 12'h000, 8'h00);
		send_word(bmw_pkg::CMD_COLL_RD, 12'h000, 8'h00);
		send_word(bmw_pkg::CMD_SET_CTRL, 12'h000, 8'(1 << bmw_pkg::CTL_OR));
		send_word(bmw_pkg::CMD_MAGIC_WR, 12'hfff, 8'h0f);
		send_word(bmw_pkg::CMD_PLAIN_RD, 12'hfff, 8'h00);
		send_word(bmw_pkg::CMD_SET_CTRL, 12'h000, 8'hff);
		send_word(bmw_pkg::CMD_MAGIC_WR, 12'h800, 8'h3c);
	endtask

	// Random traffic weighted toward magic writes into a small moving window
	// so that reads, collisions and carries land on bytes already drawn.
	// Every 64 words the window moves and sender gaps are switched on or off.
	task automatic test_random_traffic();
		int                         pick;
		int                         sent;
		int                         base;
		logic [bmw_pkg::CMD_W-1:0]  c;
		logic [bmw_pkg::ADDR_W-1:0] a;
		logic [7:0]                 d;
		sent = 0;
		base = 0;
		for (int i = 0; sent < RANDOM_WORDS; i++) begin
			if (i % 64 == 0) begin
				idle_enable = ($urandom_range(0, 3) != 0);
				base = $urandom_range(0, bmw_pkg::ADDR_SPAN - 16);
			end
			pick = $urandom_range(0, 99);
			if (pick < 6)
				c = bmw_pkg::CMD_SET_CTRL;
			else if (pick < 10)
				c = bmw_pkg::CMD_SET_COLOR;
			else if (pick < 60)
				c = bmw_pkg::CMD_MAGIC_WR;
			else if (pick < 72)
				c = bmw_pkg::CMD_PLAIN_WR;
			else if (pick < 88)
				c = bmw_pkg::CMD_PLAIN_RD;
			else if (pick < 96)
				c = bmw_pkg::CMD_COLL_RD;
			else
				c = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
			a = ($urandom_range(0, 3) != 0) ? bmw_pkg::ADDR_W'(base + $urandom_range(0, 15))
				: bmw_pkg::ADDR_W'($urandom);
			d = 8'($urandom);
			send_word(c, a, d);
			// undecoded commands do no work, so they do not count
			if (c != CMD_SPARE6 && c != CMD_SPARE7)
				sent++;
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		foreach (vram_shadow[i])
			vram_shadow[i] = 8'h00;
		ctl_shadow = '0;
		colors_shadow = '0;
		nib_sel_shadow = 1'b0;
		carry_shadow = 8'h00;
		coll_shadow = 8'h00;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// busy covers the RAM clear sweep, so the first word just waits
		test_plain_access();
		test_nibble_expand();
		test_shift_and_rotate();
		test_combine_and_collision();
		test_random_traffic();

		start <= 1'b0;
		while (expected_rdata_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#RUN_LIMIT;
		$display("[%0t] timeout, %0d results outstanding", $time, expected_rdata_q.size());
		$display("status: fail");
		$finish;
	end

endmodule
